FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl of the framed command parser
// every macro samples on clock; reset is synchronous and active high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define FCP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define FCP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/fcp_pkg.sv
// shared types, character codes and result codes of the framed command parser
// used by the front stage, the token queue, the back end and the top level

package fcp_pkg;

   // default limits of the parameter store
   localparam int DEF_MAX_SETS   = 8;
   localparam int DEF_MAX_VALUES = 4;

   // depth of the token queue between front and back
   localparam int Q_DEPTH = 2;

   // character codes
   localparam logic [7:0] CH_OPEN  = 8'h3C;
   localparam logic [7:0] CH_CLOSE = 8'h3E;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CASE_GAP = 8'h20;

   // kept-character and held-whitespace counts saturate here
   localparam logic [2:0] POS_SAT  = 3'd5;
   localparam logic [2:0] POS_SKIP = 3'd3;
   localparam logic [2:0] POS_VAL  = 3'd4;

   // command codes
   localparam logic [2:0] CODE_CON     = 3'd0;
   localparam logic [2:0] CODE_MOV     = 3'd1;
   localparam logic [2:0] CODE_REF     = 3'd2;
   localparam logic [2:0] CODE_SRV     = 3'd3;
   localparam logic [2:0] CODE_WAI     = 3'd4;
   localparam logic [2:0] CODE_UNKNOWN = 3'd5;

   // frame status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_PARAM_ERR = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN   = 2'd2;

   // result kinds
   localparam logic KIND_VALUE  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // character class found by the front stage
   typedef enum logic [2:0] {
      TOK_OPEN  = 3'd0,
      TOK_CLOSE = 3'd1,
      TOK_SPACE = 3'd2,
      TOK_DIGIT = 3'd3,
      TOK_COMMA = 3'd4,
      TOK_HASH  = 3'd5,
      TOK_MINUS = 3'd6,
      TOK_OTHER = 3'd7
   } fcp_class_type;

   // classified character; ch is case-folded
   typedef struct packed {
      fcp_class_type tok_class;
      logic [7:0]    ch;
   } fcp_token_type;

   // one result item
   typedef struct packed {
      logic               result_kind;
      logic [2:0]         command_code;
      logic [1:0]         frame_status;
      logic [2:0]         set_number;
      logic [1:0]         param_number;
      logic signed [31:0] param_value;
      logic [3:0]         set_count;
      logic               last;
   } fcp_result_type;

   // command name lookup on the three folded name characters
   function automatic logic [2:0] fcp_match_name(input logic [7:0] n0,
                                                 input logic [7:0] n1,
                                                 input logic [7:0] n2);
      logic [23:0] nm;
      nm = {n0, n1, n2};
      if (nm == {8'h63, 8'h6F, 8'h6E}) return CODE_CON;
      else if (nm == {8'h6D, 8'h6F, 8'h76}) return CODE_MOV;
      else if (nm == {8'h72, 8'h65, 8'h66}) return CODE_REF;
      else if (nm == {8'h73, 8'h72, 8'h76}) return CODE_SRV;
      else if (nm == {8'h77, 8'h61, 8'h69}) return CODE_WAI;
      else return CODE_UNKNOWN;
   endfunction

endpackage

FILE: hw/rtl/fcp_channels_if.sv
// valid/ready channel interfaces of the framed command parser
// request channel carries one byte, response channel one result item

interface fcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface fcp_rsp_if;
   logic               valid;
   logic               ready;
   logic               result_kind;
   logic [2:0]         command_code;
   logic [1:0]         frame_status;
   logic [2:0]         set_number;
   logic [1:0]         param_number;
   logic signed [31:0] param_value;
   logic [3:0]         set_count;
   logic               last;

   modport source (output valid, output result_kind, output command_code,
                   output frame_status, output set_number, output param_number,
                   output param_value, output set_count, output last, input ready);
   modport sink (input valid, input result_kind, input command_code,
                 input frame_status, input set_number, input param_number,
                 input param_value, input set_count, input last, output ready);
endinterface

FILE: hw/rtl/fcp_front.sv
// front stage: takes request bytes, classifies and case-folds them into tokens
// depends on fcp_pkg and fcp_req_if; feeds fcp_queue
`include "assert_macros.svh"

module fcp_front import fcp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   fcp_req_if.sink       req_chan,
   output logic          tok_valid,
   output fcp_token_type tok,
   input  logic          tok_ready
);

   logic          tok_valid_ff, tok_valid_in;
   fcp_token_type tok_ff, tok_in;
   logic          accept;
   logic [7:0]    b;

   // the stage takes a byte whenever its token register is free or drains
   assign req_chan.ready = !tok_valid_ff || tok_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.rx_byte;

   // character classification and case folding
   always_comb begin
      tok_in.ch = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_GAP : b;
      priority if (b == CH_OPEN)                         tok_in.tok_class = TOK_OPEN;
      else if (b == CH_CLOSE)                            tok_in.tok_class = TOK_CLOSE;
      else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
                                                         tok_in.tok_class = TOK_SPACE;
      else if (b >= CH_ZERO && b <= CH_NINE)             tok_in.tok_class = TOK_DIGIT;
      else if (b == CH_COMMA)                            tok_in.tok_class = TOK_COMMA;
      else if (b == CH_HASH)                             tok_in.tok_class = TOK_HASH;
      else if (b == CH_MINUS)                            tok_in.tok_class = TOK_MINUS;
      else                                               tok_in.tok_class = TOK_OTHER;
   end

   // token register valid flag
   always_comb begin
      if (accept) begin
         tok_valid_in = 1'b1;
      end else if (tok_ready) begin
         tok_valid_in = 1'b0;
      end else begin
         tok_valid_in = tok_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
      end
   end

   // token payload
   always_ff @(posedge clock) begin
      if (accept) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_valid = tok_valid_ff;
   assign tok       = tok_ff;

   `FCP_ASSERT(a_digit_class, (tok_valid_ff && tok_ff.tok_class == TOK_DIGIT) |-> (tok_ff.ch >= CH_ZERO && tok_ff.ch <= CH_NINE), "digit token carries a non-digit")

endmodule

FILE: hw/rtl/fcp_queue.sv
// short token queue between front and back, held in flip-flops
// depends on fcp_pkg for the token type and the queue depth
`include "assert_macros.svh"

module fcp_queue import fcp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  fcp_token_type push_tok,
   output logic          push_ready,
   output logic          pop_valid,
   output fcp_token_type pop_tok,
   input  logic          pop_ready
);

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   fcp_token_type       entry_ff [Q_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff < CNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_tok    = entry_ff[rd_ptr_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_tok;
      end
   end

   `FCP_ASSERT(a_fill_bound, count_ff <= CNT_W'(Q_DEPTH), "token queue fill count beyond depth")

endmodule

FILE: hw/rtl/fcp_back.sv
// back end: frame parser state, value accumulation and result output register
// depends on fcp_pkg; takes tokens from fcp_queue
`include "assert_macros.svh"

module fcp_back import fcp_pkg::*; #(
   parameter int MAX_SETS           = DEF_MAX_SETS,
   parameter int MAX_VALUES_PER_SET = DEF_MAX_VALUES
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           tok_valid,
   input  fcp_token_type  tok,
   output logic           tok_ready,
   output logic           rsp_valid,
   output fcp_result_type rsp_item,
   input  logic           rsp_ready
);

   localparam int SET_W = $clog2(MAX_SETS + 1);
   localparam int VAL_W = $clog2(MAX_VALUES_PER_SET + 1);

   // two-result tokens are sent in two passes
   typedef enum logic [1:0] {
      PH_FIRST  = 2'b01,
      PH_SECOND = 2'b10
   } fcp_phase_type;

   // parser state
   logic             in_frame_ff, in_frame_in;
   logic [2:0]       pos_ff, pos_in;
   logic [7:0]       name_ff [3];
   logic [7:0]       name_in [3];
   logic [2:0]       pend_ff, pend_in;
   logic [SET_W-1:0] set_ff, set_in;
   logic [VAL_W-1:0] vidx_ff, vidx_in;
   logic [31:0]      acc_ff, acc_in;
   logic             neg_ff, neg_in;
   logic             started_ff, started_in;
   logic             failed_ff, failed_in;
   fcp_phase_type    phase_ff, phase_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   fcp_result_type   rsp_item_ff, load_item;

   // working signals
   logic [3:0]       sum_pp;
   logic [2:0]       pos_r;
   logic             failed_r;
   logic [7:0]       name_r [3];
   logic             idx_ok;
   logic             value_emit;
   logic             short_frame, close_val, close_fail;
   logic [2:0]       code_raw;
   logic [31:0]      value_word, set_wide, vidx_wide, cnt_wide;
   logic [1:0]       n_res;
   fcp_result_type   value_res, report_res;
   logic             out_free, need, fire, pop, load;

   // held whitespace is replayed ahead of a kept character
   always_comb begin
      sum_pp   = {1'b0, pos_ff} + {1'b0, pend_ff};
      pos_r    = (sum_pp >= 4'(POS_SAT)) ? POS_SAT : sum_pp[2:0];
      failed_r = failed_ff || ((pend_ff != 3'd0) && (sum_pp >= 4'(POS_SAT)));
      for (int i = 0; i < 3; i++) begin
         name_r[i] = (4'(i) >= {1'b0, pos_ff} && 4'(i) < sum_pp) ? CH_SPACE : name_ff[i];
      end
   end

   // value completion checks and result fields
   always_comb begin
      idx_ok      = (set_ff < SET_W'(MAX_SETS)) && (vidx_ff < VAL_W'(MAX_VALUES_PER_SET));
      value_word  = neg_ff ? (32'd0 - acc_ff) : acc_ff;
      set_wide    = 32'(set_ff);
      vidx_wide   = 32'(vidx_ff);
      cnt_wide    = set_wide + 32'd1;
      short_frame = !in_frame_ff || (pos_ff < POS_SKIP);
      close_val   = !short_frame && (pos_ff >= POS_SAT) && !failed_ff && idx_ok;
      close_fail  = failed_ff || ((pos_ff >= POS_SAT) && !idx_ok);
      code_raw    = fcp_match_name(name_ff[0], name_ff[1], name_ff[2]);
   end

   // value result
   always_comb begin
      value_res.result_kind  = KIND_VALUE;
      value_res.command_code = CODE_CON;
      value_res.frame_status = STATUS_OK;
      value_res.set_number   = set_wide[2:0];
      value_res.param_number = vidx_wide[1:0];
      value_res.param_value  = value_word;
      value_res.set_count    = 4'd0;
      value_res.last         = (tok.tok_class != TOK_CLOSE);
   end

   // frame end report
   always_comb begin
      report_res.result_kind  = KIND_REPORT;
      report_res.set_number   = 3'd0;
      report_res.param_number = 2'd0;
      report_res.param_value  = 32'sd0;
      report_res.last         = 1'b1;
      if (short_frame) begin
         report_res.command_code = CODE_UNKNOWN;
         report_res.frame_status = STATUS_PARAM_ERR;
         report_res.set_count    = 4'd0;
      end else if (close_fail) begin
         report_res.command_code = code_raw;
         report_res.frame_status = STATUS_PARAM_ERR;
         report_res.set_count    = 4'd0;
      end else begin
         report_res.command_code = code_raw;
         report_res.frame_status = (code_raw == CODE_UNKNOWN) ? STATUS_UNKNOWN : STATUS_OK;
         report_res.set_count    = (pos_ff >= POS_SAT) ? cnt_wide[3:0] : 4'd0;
      end
   end

   // next parser state when the head token is carried out
   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      pend_in     = pend_ff;
      set_in      = set_ff;
      vidx_in     = vidx_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      started_in  = started_ff;
      failed_in   = failed_ff;
      value_emit  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         name_in[i] = name_ff[i];
      end
      unique case (tok.tok_class)
         TOK_OPEN, TOK_CLOSE: begin
            in_frame_in = (tok.tok_class == TOK_OPEN);
            pos_in      = '0;
            pend_in     = '0;
            set_in      = '0;
            vidx_in     = '0;
            acc_in      = '0;
            neg_in      = 1'b0;
            started_in  = 1'b0;
            failed_in   = 1'b0;
            for (int i = 0; i < 3; i++) begin
               name_in[i] = 8'd0;
            end
         end
         TOK_SPACE: begin
            if (in_frame_ff && pos_ff != 3'd0 && pend_ff != POS_SAT) begin
               pend_in = pend_ff + 3'd1;
            end
         end
         TOK_DIGIT, TOK_COMMA, TOK_HASH, TOK_MINUS, TOK_OTHER: begin
            if (in_frame_ff) begin
               pend_in   = '0;
               failed_in = failed_r;
               for (int i = 0; i < 3; i++) begin
                  name_in[i] = name_r[i];
               end
               if (pos_r < POS_SKIP) begin
                  name_in[pos_r[1:0]] = tok.ch;
               end else if (pos_r >= POS_VAL && !failed_r) begin
                  unique case (tok.tok_class)
                     TOK_COMMA, TOK_HASH: begin
                        if (idx_ok) begin
                           value_emit = 1'b1;
                           acc_in     = '0;
                           neg_in     = 1'b0;
                           started_in = 1'b0;
                           if (tok.tok_class == TOK_HASH) begin
                              set_in  = set_ff + SET_W'(1);
                              vidx_in = '0;
                           end else begin
                              vidx_in = vidx_ff + VAL_W'(1);
                           end
                        end else begin
                           failed_in = 1'b1;
                        end
                     end
                     TOK_DIGIT: begin
                        acc_in     = (acc_ff << 3) + (acc_ff << 1) + {28'd0, tok.ch[3:0]};
                        started_in = 1'b1;
                     end
                     TOK_MINUS: begin
                        if (!started_ff) begin
                           neg_in     = 1'b1;
                           started_in = 1'b1;
                        end else begin
                           failed_in = 1'b1;
                        end
                     end
                     default: begin
                        failed_in = 1'b1;
                     end
                  endcase
               end
               pos_in = (pos_r == POS_SAT) ? POS_SAT : pos_r + 3'd1;
            end
         end
      endcase
   end

   // number of results caused by the head token
   always_comb begin
      if (tok.tok_class == TOK_CLOSE) begin
         n_res = close_val ? 2'd2 : 2'd1;
      end else begin
         n_res = value_emit ? 2'd1 : 2'd0;
      end
   end

   // handshake between the head token and the output register
   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      need     = (n_res != 2'd0);
      fire     = tok_valid && (!need || out_free);
      if (n_res == 2'd2 && phase_ff == PH_FIRST) begin
         pop       = 1'b0;
         load      = fire;
         load_item = value_res;
         phase_in  = fire ? PH_SECOND : phase_ff;
      end else begin
         pop       = fire;
         load      = fire && need;
         load_item = (tok.tok_class == TOK_CLOSE) ? report_res : value_res;
         phase_in  = fire ? PH_FIRST : phase_ff;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         pend_ff     <= '0;
         set_ff      <= '0;
         vidx_ff     <= '0;
         acc_ff      <= '0;
         neg_ff      <= 1'b0;
         started_ff  <= 1'b0;
         failed_ff   <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            name_ff[i] <= 8'd0;
         end
      end else if (pop) begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         pend_ff     <= pend_in;
         set_ff      <= set_in;
         vidx_ff     <= vidx_in;
         acc_ff      <= acc_in;
         neg_ff      <= neg_in;
         started_ff  <= started_in;
         failed_ff   <= failed_in;
         for (int i = 0; i < 3; i++) begin
            name_ff[i] <= name_in[i];
         end
      end
   end

   // phase and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_item_ff <= load_item;
      end
   end

   assign tok_ready = pop;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `FCP_ASSERT(a_second_pass_head, (phase_ff == PH_SECOND) |-> (tok_valid && tok.tok_class == TOK_CLOSE), "second pass without a close token at the head")
   `FCP_ASSERT(a_second_pass_out, (phase_ff == PH_SECOND) |-> (rsp_valid_ff && rsp_item_ff.result_kind == KIND_VALUE && !rsp_item_ff.last), "second pass without a pending value result")
   `FCP_ASSERT(a_count_sat, (pos_ff <= POS_SAT) && (pend_ff <= POS_SAT), "character counts beyond saturation")

endmodule

FILE: hw/rtl/framed_command_parser_unit.sv
// Framed command parser, top level.
// The request channel (req_chan) carries one received serial byte per request,
// accepted at a rising edge with valid and ready both high. Frames look like
// <nam?v,v#v,...>; the response channel (rsp_chan) returns one value result for
// each completed value and a frame end report at every '>', the report giving
// command code, set count and status. The last flag marks the final result
// caused by a request byte.
// Throughput: one request byte per cycle when nothing stalls. A '>' that
// completes a value makes two results and holds the back end for both; every
// other byte makes at most one result.
// A result passes through the classification register, the token queue and
// the back end's output register.
// Reset clears the frame state, the token queue and the output register; the
// block is ready to take a byte as soon as reset is released.
// When the receiver stalls, the output register holds its result, the back end
// keeps working on bytes that make no result, and the two-entry queue and the
// front register absorb further bytes before req_chan.ready drops.

module framed_command_parser_unit import fcp_pkg::*; #(
   parameter int MAX_SETS           = DEF_MAX_SETS,
   parameter int MAX_VALUES_PER_SET = DEF_MAX_VALUES
) (
   input logic        clock,
   input logic        reset,
   fcp_req_if.sink    req_chan,
   fcp_rsp_if.source  rsp_chan
);

   logic           ft_valid, ft_ready;
   fcp_token_type  ft_tok;
   logic           qb_valid, qb_ready;
   fcp_token_type  qb_tok;
   logic           res_valid;
   fcp_result_type res_item;

   // byte classification
   fcp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .tok_valid (ft_valid),
      .tok       (ft_tok),
      .tok_ready (ft_ready)
   );

   // decoupling queue
   fcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (ft_valid),
      .push_tok   (ft_tok),
      .push_ready (ft_ready),
      .pop_valid  (qb_valid),
      .pop_tok    (qb_tok),
      .pop_ready  (qb_ready)
   );

   // frame parsing and result output
   fcp_back #(
      .MAX_SETS           (MAX_SETS),
      .MAX_VALUES_PER_SET (MAX_VALUES_PER_SET)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (qb_valid),
      .tok       (qb_tok),
      .tok_ready (qb_ready),
      .rsp_valid (res_valid),
      .rsp_item  (res_item),
      .rsp_ready (rsp_chan.ready)
   );

   // response channel
   assign rsp_chan.valid        = res_valid;
   assign rsp_chan.result_kind  = res_item.result_kind;
   assign rsp_chan.command_code = res_item.command_code;
   assign rsp_chan.frame_status = res_item.frame_status;
   assign rsp_chan.set_number   = res_item.set_number;
   assign rsp_chan.param_number = res_item.param_number;
   assign rsp_chan.param_value  = res_item.param_value;
   assign rsp_chan.set_count    = res_item.set_count;
   assign rsp_chan.last         = res_item.last;

endmodule
